// File: hdl/i2csc_pkg.sv
// ----------------------------------------------------------------------------
// i2csc_pkg
// Shared widths, codes and constants of the I2C slave command engine.
// ----------------------------------------------------------------------------
package i2csc_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 6;
  localparam int PADDR_W              = 3;
  localparam int PDATA_W              = 32;
  localparam int ADDR_W               = 7;
  localparam int PAYLOAD_BYTES        = 6;
  localparam int PAYLOAD_W            = 8 * PAYLOAD_BYTES;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [7:0] CMD_RECEIVE = 8'h01;
  localparam logic [7:0] CMD_NOTIFY  = 8'h10;
  localparam logic [7:0] CMD_PATTERN = 8'h20;

  localparam logic [0:0] REG_SLAVE_ADDRESS = 1'b0;
  localparam logic [ADDR_W-1:0] SLAVE_ADDRESS_RESET = 7'd8;

  function automatic logic [7:0] pattern_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hde;
      3'd1:    b = 8'had;
      3'd2:    b = 8'hbe;
      3'd3:    b = 8'hef;
      3'd4:    b = 8'hcc;
      3'd5:    b = 8'haa;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/i2c_slave_command_engine.sv
// ----------------------------------------------------------------------------
// i2c_slave_command_engine
// Bit-level I2C slave: 7-bit address match, command decode, receive and
// transmit byte stores, one bus event per request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in       | input     | in_valid_i/in_stall_o | opcode, sda_sample, load_*
//  out      | output    | out_valid_o/out_stall_i | sda_pull_low, busy_res, ...
//  config   | input     | APB psel/penable      | slave_address at 0x0
//
//  One request per cycle unless stalled; its result appears in the output register on the
//  next cycle. The bus state and both byte stores update at the accepting edge.
//  A request is taken whenever the output register is empty or being taken.
//  Reset returns to idle, address 8, SDA released, stores cleared.
// ----------------------------------------------------------------------------
module i2c_slave_command_engine #(
  parameter int BufferBytes = i2csc_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          opcode_i,
  input  logic                                sda_sample_i,
  input  logic [2:0]                          load_index_i,
  input  logic [7:0]                          load_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                sda_pull_low_o,
  output logic                                busy_res_o,
  output logic                                cmd_done_o,
  output logic [7:0]                          last_command_o,
  output logic [i2csc_pkg::PAYLOAD_W-1:0]     rx_payload_o,
  output logic                                nack_seen_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2csc_pkg::PADDR_W-1:0]       paddr,
  input  logic [i2csc_pkg::PDATA_W-1:0]       pwdata,
  output logic [i2csc_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);
  import i2csc_pkg::*;

  localparam int SlotW = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(BufferBytes - 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ADDRESS, PH_RW, PH_ACK_READ, PH_ACK_WRITE,
    PH_CONTROL, PH_RECEIVE, PH_RX_ACK, PH_SEND, PH_WAIT_MACK
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic              fin_q, fin_d;
  logic [7:0]        cmd_q, cmd_d;
  logic              sda_q, sda_d;
  logic [7:0]        rx_q [BufferBytes];
  logic [7:0]        rx_d [BufferBytes];
  logic [7:0]        tx_q [BufferBytes];
  logic [7:0]        tx_d [BufferBytes];
  logic [ADDR_W-1:0] addr_q;

  logic              done_d, nack_d;
  logic              in_acc, cfg_wr;
  logic [7:0]        sh_in;
  logic [3:0]        cnt_inc;
  logic [SlotW-1:0]  slot_inc;
  logic [PAYLOAD_W-1:0] payload_d;

  logic                 out_valid_q;
  logic                 out_sda_q, out_busy_q, out_done_q, out_nack_q;
  logic [7:0]           out_cmd_q;
  logic [PAYLOAD_W-1:0] out_payload_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready & (paddr[2] == REG_SLAVE_ADDRESS);
  assign prdata     = (paddr[2] == REG_SLAVE_ADDRESS) ?
                      PDATA_W'(addr_q) : '0;

  assign sh_in    = {shift_q[6:0], sda_sample_i};
  assign cnt_inc  = bit_cnt_q + 4'd1;
  assign slot_inc = slot_q + SlotW'(1);

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    slot_d    = slot_q;
    fin_d     = fin_q;
    cmd_d     = cmd_q;
    sda_d     = sda_q;
    rx_d      = rx_q;
    tx_d      = tx_q;
    done_d    = 1'b0;
    nack_d    = 1'b0;
    case (opcode_i)
      OP_START: begin
        phase_d   = PH_ADDRESS;
        bit_cnt_d = '0;
        shift_d   = '0;
        fin_d     = 1'b0;
        sda_d     = 1'b0;
      end
      OP_LOAD: begin
        if ({1'b0, load_index_i} < 4'(BufferBytes)) begin
          tx_d[load_index_i[SlotW-1:0]] = load_byte_i;
        end
      end
      OP_EDGE: begin
        case (phase_q)
          PH_ADDRESS: begin
            shift_d   = sh_in;
            bit_cnt_d = cnt_inc;
            if (cnt_inc >= 4'd7) begin
              if (sh_in[6:0] == addr_q) begin
                phase_d   = PH_RW;
                bit_cnt_d = '0;
              end else begin
                phase_d   = PH_IDLE;
                sda_d     = 1'b0;
                bit_cnt_d = '0;
                fin_d     = 1'b0;
              end
            end
          end
          PH_RW: begin
            phase_d = sda_sample_i ? PH_ACK_READ : PH_ACK_WRITE;
            sda_d   = 1'b1;
          end
          PH_ACK_READ: begin
            slot_d    = '0;
            shift_d   = tx_q[0];
            bit_cnt_d = '0;
            fin_d     = (LastSlot == '0);
            phase_d   = PH_SEND;
            sda_d     = ~tx_q[0][7];
          end
          PH_ACK_WRITE: begin
            phase_d   = PH_CONTROL;
            sda_d     = 1'b0;
            bit_cnt_d = '0;
            shift_d   = '0;
          end
          PH_CONTROL: begin
            shift_d   = sh_in;
            bit_cnt_d = cnt_inc;
            if (cnt_inc >= 4'd8) begin
              bit_cnt_d = '0;
              cmd_d     = sh_in;
              if (sh_in == CMD_RECEIVE) begin
                slot_d  = LastSlot;
                fin_d   = 1'b0;
                phase_d = PH_RX_ACK;
                sda_d   = 1'b1;
              end else if (sh_in == CMD_NOTIFY) begin
                done_d  = 1'b1;
                fin_d   = 1'b1;
                phase_d = PH_RX_ACK;
                sda_d   = 1'b1;
              end else if (sh_in == CMD_PATTERN) begin
                for (int i = 0; i < BufferBytes; i++) begin
                  if (i < PAYLOAD_BYTES) begin
                    tx_d[i] = pattern_byte(3'(i));
                  end
                end
                fin_d   = 1'b0;
                phase_d = PH_RX_ACK;
                sda_d   = 1'b1;
              end else begin
                phase_d = PH_IDLE;
                sda_d   = 1'b0;
                fin_d   = 1'b0;
              end
            end
          end
          PH_RECEIVE: begin
            shift_d   = sh_in;
            bit_cnt_d = cnt_inc;
            if (cnt_inc >= 4'd8) begin
              bit_cnt_d    = '0;
              rx_d[slot_q] = sh_in;
              if (slot_q == '0) begin
                done_d = 1'b1;
                fin_d  = 1'b1;
              end else begin
                slot_d = slot_q - SlotW'(1);
              end
              phase_d = PH_RX_ACK;
              sda_d   = 1'b1;
            end
          end
          PH_RX_ACK: begin
            sda_d     = 1'b0;
            bit_cnt_d = '0;
            shift_d   = '0;
            if (fin_q) begin
              phase_d = PH_IDLE;
              fin_d   = 1'b0;
            end else begin
              phase_d = (cmd_q == CMD_PATTERN) ? PH_CONTROL : PH_RECEIVE;
            end
          end
          PH_SEND: begin
            bit_cnt_d = cnt_inc;
            if (cnt_inc >= 4'd8) begin
              phase_d = PH_WAIT_MACK;
              sda_d   = 1'b0;
            end else begin
              sda_d = ~shift_q[3'd7 - cnt_inc[2:0]];
            end
          end
          PH_WAIT_MACK: begin
            if (sda_sample_i) begin
              nack_d    = 1'b1;
              phase_d   = PH_IDLE;
              sda_d     = 1'b0;
              bit_cnt_d = '0;
              fin_d     = 1'b0;
            end else if (fin_q) begin
              phase_d   = PH_IDLE;
              sda_d     = 1'b0;
              bit_cnt_d = '0;
              fin_d     = 1'b0;
            end else begin
              slot_d    = slot_inc;
              shift_d   = tx_q[slot_inc];
              bit_cnt_d = '0;
              fin_d     = (slot_inc >= LastSlot);
              phase_d   = PH_SEND;
              sda_d     = ~tx_q[slot_inc][7];
            end
          end
          default: begin
            phase_d   = PH_IDLE;
            sda_d     = 1'b0;
            bit_cnt_d = '0;
            fin_d     = 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    payload_d = '0;
    for (int i = 0; i < BufferBytes; i++) begin
      if (i < PAYLOAD_BYTES) begin
        payload_d[8*i +: 8] = rx_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= SLAVE_ADDRESS_RESET;
    end else if (cfg_wr) begin
      addr_q <= pwdata[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_cnt_q     <= '0;
      shift_q       <= '0;
      slot_q        <= '0;
      fin_q         <= 1'b0;
      cmd_q         <= '0;
      sda_q         <= 1'b0;
      for (int i = 0; i < BufferBytes; i++) begin
        rx_q[i] <= '0;
        tx_q[i] <= '0;
      end
      out_valid_q   <= 1'b0;
      out_sda_q     <= 1'b0;
      out_busy_q    <= 1'b0;
      out_done_q    <= 1'b0;
      out_cmd_q     <= '0;
      out_payload_q <= '0;
      out_nack_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q       <= phase_d;
      bit_cnt_q     <= bit_cnt_d;
      shift_q       <= shift_d;
      slot_q        <= slot_d;
      fin_q         <= fin_d;
      cmd_q         <= cmd_d;
      sda_q         <= sda_d;
      rx_q          <= rx_d;
      tx_q          <= tx_d;
      out_valid_q   <= 1'b1;
      out_sda_q     <= sda_d;
      out_busy_q    <= (phase_d != PH_IDLE) && (phase_d != PH_ADDRESS);
      out_done_q    <= done_d;
      out_cmd_q     <= cmd_d;
      out_payload_q <= payload_d;
      out_nack_q    <= nack_d;
    end else if (!out_stall_i) begin
      out_valid_q   <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sda_pull_low_o = out_sda_q;
  assign busy_res_o     = out_busy_q;
  assign cmd_done_o     = out_done_q;
  assign last_command_o = out_cmd_q;
  assign rx_payload_o   = out_payload_q;
  assign nack_seen_o    = out_nack_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_released_when_unaddressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> !sda_pull_low_o)
    else $error("SDA driven while not addressed");

  a_done_during_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cmd_done_o) |-> (busy_res_o && sda_pull_low_o))
    else $error("command done outside an ack bit");

  a_nack_ends_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && nack_seen_o) |-> (!busy_res_o && !cmd_done_o))
    else $error("nack seen while still addressed");

endmodule

// File: tb/i2c_slave_command_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_command_engine_tb
// Feeds the I2C slave a stream of bus events: whole read and write frames
// with random content, cut-off frames, local transmit loads and noise. A
// built-in model of the slave predicts the status after each event, and every
// returned status is compared field by field. Both handshakes idle and stall
// at random. The slave address is changed between phases over the APB port.
// ----------------------------------------------------------------------------
module i2c_slave_command_engine_tb;
  import i2csc_pkg::*;

  localparam int         SLOTS  = BUFFER_BYTES_DEFAULT;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [7:0] TX_PATTERN [SLOTS] = '{8'hde, 8'had, 8'hbe, 8'hef, 8'hcc, 8'haa};

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_ADDRESS, BUS_RW, BUS_ACK_READ, BUS_ACK_WRITE,
    BUS_CONTROL, BUS_RECEIVE, BUS_RX_ACK, BUS_SEND, BUS_WAIT_MACK
  } bus_phase_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic       sda;
    logic [2:0] load_index;
    logic [7:0] load_byte;
  } bus_event_t;

  typedef struct packed {
    logic                 sda_pull_low;
    logic                 busy;
    logic                 cmd_done;
    logic [7:0]           last_command;
    logic [PAYLOAD_W-1:0] rx_payload;
    logic                 nack_seen;
  } bus_status_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic       req_valid = 1'b0;
  bus_event_t held      = '0;
  logic       in_stall;
  logic       rsp_stall = 1'b0;

  logic                 out_valid;
  logic                 sda_pull_low;
  logic                 busy_res;
  logic                 cmd_done;
  logic [7:0]           last_command;
  logic [PAYLOAD_W-1:0] rx_payload;
  logic                 nack_seen;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bus_event_t  pending_events[$];
  bus_event_t  burst[$];
  bus_status_t expected_status[$];
  bus_status_t want_status;
  int          items_queued   = 0;
  int          error_count    = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;

  bus_phase_e        m_phase   = BUS_IDLE;
  logic [3:0]        m_bits    = '0;
  logic [7:0]        m_shift   = '0;
  logic [2:0]        m_slot    = '0;
  logic              m_finish  = 1'b0;
  logic [7:0]        m_command = '0;
  logic              m_sda     = 1'b0;
  logic [ADDR_W-1:0] m_address = SLAVE_ADDRESS_RESET;
  logic [7:0]        m_rx [SLOTS] = '{default: 8'h00};
  logic [7:0]        m_tx [SLOTS] = '{default: 8'h00};

  i2c_slave_command_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (held.opcode),
    .sda_sample_i   (held.sda),
    .load_index_i   (held.load_index),
    .load_byte_i    (held.load_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (rsp_stall),
    .sda_pull_low_o (sda_pull_low),
    .busy_res_o     (busy_res),
    .cmd_done_o     (cmd_done),
    .last_command_o (last_command),
    .rx_payload_o   (rx_payload),
    .nack_seen_o    (nack_seen),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void bus_release();
    m_phase  = BUS_IDLE;
    m_sda    = 1'b0;
    m_bits   = '0;
    m_finish = 1'b0;
  endfunction

  function automatic void ack_byte();
    m_phase = BUS_RX_ACK;
    m_sda   = 1'b1;
  endfunction

  function automatic void fetch_tx_byte();
    m_shift  = m_tx[m_slot];
    m_bits   = '0;
    m_finish = (m_slot >= 3'(SLOTS - 1));
    m_phase  = BUS_SEND;
    m_sda    = ~m_shift[7];
  endfunction

  function automatic logic shift_bit(input logic b, input int need);
    m_shift = {m_shift[6:0], b};
    m_bits  = m_bits + 4'd1;
    return m_bits >= need;
  endfunction

  function automatic bus_status_t advance_bus(input bus_event_t ev);
    bus_status_t st;
    st = '0;
    case (ev.opcode)
      OP_START: begin
        m_phase  = BUS_ADDRESS;
        m_bits   = '0;
        m_shift  = '0;
        m_finish = 1'b0;
        m_sda    = 1'b0;
      end
      OP_EDGE: begin
        case (m_phase)
          BUS_ADDRESS: begin
            if (shift_bit(ev.sda, 7)) begin
              if (m_shift[6:0] == m_address) begin
                m_phase = BUS_RW;
                m_bits  = '0;
              end else begin
                bus_release();
              end
            end
          end
          BUS_RW: begin
            m_phase = ev.sda ? BUS_ACK_READ : BUS_ACK_WRITE;
            m_sda   = 1'b1;
          end
          BUS_ACK_READ: begin
            m_slot = '0;
            fetch_tx_byte();
          end
          BUS_ACK_WRITE: begin
            m_phase = BUS_CONTROL;
            m_sda   = 1'b0;
            m_bits  = '0;
            m_shift = '0;
          end
          BUS_CONTROL: begin
            if (shift_bit(ev.sda, 8)) begin
              m_bits    = '0;
              m_command = m_shift;
              case (m_shift)
                CMD_RECEIVE: begin
                  m_slot   = 3'(SLOTS - 1);
                  m_finish = 1'b0;
                  ack_byte();
                end
                CMD_NOTIFY: begin
                  st.cmd_done = 1'b1;
                  m_finish    = 1'b1;
                  ack_byte();
                end
                CMD_PATTERN: begin
                  for (int i = 0; i < SLOTS; i++) m_tx[i] = TX_PATTERN[i];
                  m_finish = 1'b0;
                  ack_byte();
                end
                default: bus_release();
              endcase
            end
          end
          BUS_RECEIVE: begin
            if (shift_bit(ev.sda, 8)) begin
              m_bits       = '0;
              m_rx[m_slot] = m_shift;
              if (m_slot == 3'd0) begin
                st.cmd_done = 1'b1;
                m_finish    = 1'b1;
              end else begin
                m_slot = m_slot - 3'd1;
              end
              ack_byte();
            end
          end
          BUS_RX_ACK: begin
            m_sda   = 1'b0;
            m_bits  = '0;
            m_shift = '0;
            if (m_finish) bus_release();
            else m_phase = (m_command == CMD_PATTERN) ? BUS_CONTROL : BUS_RECEIVE;
          end
          BUS_SEND: begin
            m_bits = m_bits + 4'd1;
            if (m_bits >= 4'd8) begin
              m_phase = BUS_WAIT_MACK;
              m_sda   = 1'b0;
            end else begin
              m_sda = ~m_shift[3'(7 - m_bits)];
            end
          end
          BUS_WAIT_MACK: begin
            if (ev.sda) begin
              st.nack_seen = 1'b1;
              bus_release();
            end else if (m_finish) begin
              bus_release();
            end else begin
              m_slot = m_slot + 3'd1;
              fetch_tx_byte();
            end
          end
          default: bus_release();
        endcase
      end
      OP_LOAD: begin
        if (ev.load_index < SLOTS) m_tx[ev.load_index] = ev.load_byte;
      end
      default: ;
    endcase
    st.sda_pull_low = m_sda;
    st.busy         = (m_phase != BUS_IDLE) && (m_phase != BUS_ADDRESS);
    st.last_command = m_command;
    for (int i = 0; i < SLOTS; i++) st.rx_payload[8*i +: 8] = m_rx[i];
    return st;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !in_stall) expected_status.push_back(advance_bus(held));
      if (!req_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          held      <= pending_events.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input string what);
    error_count++;
    if (error_count <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (!rst_n) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !rsp_stall) begin
        if (expected_status.size() == 0) begin
          flag_mismatch("status returned with no request pending");
        end else begin
          want_status = expected_status.pop_front();
          if (sda_pull_low !== want_status.sda_pull_low)
            flag_mismatch($sformatf("sda_pull_low got %b want %b",
                                    sda_pull_low, want_status.sda_pull_low));
          if (busy_res !== want_status.busy)
            flag_mismatch($sformatf("busy_res got %b want %b", busy_res, want_status.busy));
          if (cmd_done !== want_status.cmd_done)
            flag_mismatch($sformatf("cmd_done got %b want %b", cmd_done, want_status.cmd_done));
          if (last_command !== want_status.last_command)
            flag_mismatch($sformatf("last_command got %h want %h",
                                    last_command, want_status.last_command));
          if (rx_payload !== want_status.rx_payload)
            flag_mismatch($sformatf("rx_payload got %h want %h",
                                    rx_payload, want_status.rx_payload));
          if (nack_seen !== want_status.nack_seen)
            flag_mismatch($sformatf("nack_seen got %b want %b", nack_seen, want_status.nack_seen));
        end
      end
    end
  end

  function automatic void add_event(input logic [1:0] op, input logic b,
                                    input logic [2:0] idx, input logic [7:0] data);
    bus_event_t ev;
    ev.opcode     = op;
    ev.sda        = b;
    ev.load_index = idx;
    ev.load_byte  = data;
    burst.push_back(ev);
  endfunction

  function automatic void add_edge(input logic b);
    add_event(OP_EDGE, b, 3'($urandom), 8'($urandom));
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) add_edge(v[i]);
  endfunction

  function automatic void add_header(input logic [6:0] a, input logic rd);
    add_event(OP_START, 1'($urandom), 3'($urandom), 8'($urandom));
    for (int i = 6; i >= 0; i--) add_edge(a[i]);
    add_edge(rd);
    add_edge(1'($urandom));
  endfunction

  function automatic void commit_burst(input bit cut);
    int keep;
    keep = cut ? $urandom_range(1, burst.size() - 1) : burst.size();
    for (int i = 0; i < keep; i++) pending_events.push_back(burst[i]);
    items_queued += keep;
    burst.delete();
  endfunction

  function automatic void add_payload();
    repeat (SLOTS) begin
      add_byte(8'($urandom));
      add_edge(1'($urandom));
    end
  endfunction

  task automatic queue_transaction(input logic [6:0] own);
    int         kind;
    int         n;
    logic [6:0] a;
    logic [7:0] c;
    kind = $urandom_range(99);
    a    = ($urandom_range(9) == 0) ? 7'($urandom) : own;
    if (kind < 20) begin
      add_header(a, 1'b0);
      add_byte(CMD_RECEIVE);
      add_edge(1'($urandom));
      add_payload();
    end else if (kind < 32) begin
      add_header(a, 1'b0);
      add_byte(CMD_NOTIFY);
      add_edge(1'($urandom));
    end else if (kind < 44) begin
      add_header(a, 1'b0);
      add_byte(CMD_PATTERN);
      add_edge(1'($urandom));
      case ($urandom_range(3))
        0: c = CMD_NOTIFY;
        1: c = CMD_PATTERN;
        2: c = CMD_RECEIVE;
        default: c = 8'($urandom);
      endcase
      add_byte(c);
      add_edge(1'($urandom));
      if (c == CMD_RECEIVE) add_payload();
    end else if (kind < 70) begin
      add_header(a, 1'b1);
      n = $urandom_range(1, SLOTS);
      for (int k = 0; k < n; k++) begin
        add_byte(8'($urandom));
        if (k < n - 1) add_edge(1'b0);
        else if (n == SLOTS) add_edge(1'($urandom));
        else add_edge($urandom_range(3) != 0);
      end
    end else if (kind < 78) begin
      c = 8'($urandom);
      while (c == CMD_RECEIVE || c == CMD_NOTIFY || c == CMD_PATTERN) c = 8'($urandom);
      add_header(a, 1'b0);
      add_byte(c);
      add_edge(1'($urandom));
    end else if (kind < 84) begin
      add_header(own ^ 7'($urandom_range(1, 127)), 1'($urandom));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 4)) add_event(OP_LOAD, 1'($urandom), 3'($urandom), 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6))
        add_event(2'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
    end
    commit_burst(kind < 78 && $urandom_range(99) < 12);
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || req_valid || expected_status.size() != 0);
  endtask

  task automatic write_slave_address(input logic [ADDR_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_SLAVE_ADDRESS);
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    m_address = value;
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] addr, input int gap, input int stall,
                           input int target);
    wait_for_drain();
    repeat (4) @(posedge clk_i);
    write_slave_address(addr);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    while (items_queued < target) queue_transaction(addr);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    send_gap_pct   = 32;
    recv_stall_pct = 59;

    add_edge(1'b1);
    add_event(OP_NOP, 1'b1, 3'd7, 8'hff);
    add_event(OP_LOAD, 1'b0, 3'd0, 8'hff);
    add_event(OP_LOAD, 1'b1, 3'd7, 8'h00);
    add_header(SLAVE_ADDRESS_RESET, 1'b1);
    add_event(OP_LOAD, 1'b0, 3'd5, 8'h00);
    add_event(OP_START, 1'b0, 3'd0, 8'h00);
    add_byte(8'hff);
    commit_burst(1'b0);

    run_phase(7'h7f, 32, 59, 540);
    run_phase(7'h00, 59, 32, 1045);
    run_phase(7'($urandom_range(1, 126)), 0, 0, 1550);

    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
